// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL of the line sensor position estimator.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lspe_pkg.sv =====
// Package for the line sensor position estimator: widths, reset values,
// item kinds, register indexes and sequencer states. No dependencies.
package lspe_pkg;

  localparam int DEFAULT_SENSOR_COUNT = 9;
  localparam int DEFAULT_TIMEOUT      = 2500;

  localparam int KIND_W    = 2;
  localparam int IDX_IN_W  = 4;
  localparam int TIME_W    = 12;
  localparam int NORM_W    = 10;
  localparam int POS_W     = 13;
  localparam int WSUM_W    = 27;
  localparam int WGT_W     = 14;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 12;

  localparam int S_DATA_W = 16;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 16;
  localparam int M_USER_W = 2;

  localparam int FULL_SCALE = 1000;
  localparam int POS_MAX    = 8191;
  localparam int HELD_RESET = 4000;

  localparam int PRESET_MIN_RST = 45;
  localparam int PRESET_MAX_RST = 600;
  localparam int NOISE_RST      = 100;
  localparam int CONF_RST       = 500;

  typedef enum logic [KIND_W-1:0] {
    KIND_MEASURE   = 2'd0,
    KIND_CALIBRATE = 2'd1,
    KIND_CLEAR     = 2'd2,
    KIND_PRESET    = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESET_MIN  = 2'd0,
    REG_PRESET_MAX  = 2'd1,
    REG_NOISE_FLOOR = 2'd2,
    REG_CONFIDENCE  = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_MUL,
    ST_DIV_NORM,
    ST_PROD,
    ST_ACCUM,
    ST_CHECK,
    ST_DIV_POS,
    ST_FINISH
  } state_e;

endpackage

// ===== sv/line_sensor_position_estimator.sv =====
// Line sensor position estimator, top level; uses lspe_pkg and assert_macros.svh.
// Clear, preset, calibrate and out-of-range items are taken in idle; a measurement item keeps tready low
// through scale, multiply, the shared radix-2 divider, product and accumulate, so no new item is taken
// until it is done. The last sensor then adds check, a second division and finish, or only check and finish
// when no sensor is above the noise floor; a waiting result stalls only the next frame end.
// Reset (async, low) loads the tables to timeout/zero, clears sums, sets position 4000.
`include "assert_macros.svh"

module line_sensor_position_estimator #(
  parameter int SENSOR_COUNT = lspe_pkg::DEFAULT_SENSOR_COUNT,
  parameter int TIMEOUT      = lspe_pkg::DEFAULT_TIMEOUT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input items.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [lspe_pkg::S_DATA_W-1:0]  s_axis_tdata_i,  // sensor_index[3:0], raw_time[15:4]
  input  logic [lspe_pkg::S_USER_W-1:0]  s_axis_tuser_i,  // kind[1:0]
  // Result items.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [lspe_pkg::M_DATA_W-1:0]  m_axis_tdata_o,  // line_position[12:0], zeros[15:13]
  output logic [lspe_pkg::M_USER_W-1:0]  m_axis_tuser_o,  // position_fresh[0], line_detected[1]
  // Register writes.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lspe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lspe_pkg::CFG_W-1:0]     cfg_data_i
);
  import lspe_pkg::*;

  localparam int IDX_W   = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int DPROD_W = TIME_W + NORM_W;           // delta * 1000
  localparam int PROD_W  = NORM_W + WGT_W;            // norm * sensor weight
  localparam int CNT_W   = $clog2(WSUM_W + 1);
  localparam int THR_W   = NORM_W + $clog2(SENSOR_COUNT + 1);
  localparam int LIMIT_RAW = (SENSOR_COUNT - 1) * FULL_SCALE;
  localparam int POS_LIMIT = (LIMIT_RAW < POS_MAX) ? LIMIT_RAW : POS_MAX;

  localparam logic [TIME_W-1:0]   TIMEOUT_V = TIME_W'(TIMEOUT);
  localparam logic [IDX_IN_W-1:0] LAST_IDX  = IDX_IN_W'(SENSOR_COUNT - 1);
  localparam logic [CNT_W-1:0]    NORM_STEPS = CNT_W'(DPROD_W);
  localparam logic [CNT_W-1:0]    POS_STEPS  = CNT_W'(WSUM_W);
  localparam logic [WGT_W-1:0]    WGT_MAX  = {WGT_W{1'b1}};
  localparam logic [WSUM_W-1:0]   WSUM_MAX = {WSUM_W{1'b1}};

  state_e state_q, state_d;

  // Configuration registers.
  logic [TIME_W-1:0] preset_min_q, preset_max_q;
  logic [NORM_W-1:0] noise_floor_q, confidence_q;

  // Calibration tables and frame accumulators.
  logic [TIME_W-1:0] cal_low_q  [SENSOR_COUNT];
  logic [TIME_W-1:0] cal_high_q [SENSOR_COUNT];
  logic [WSUM_W-1:0] weighted_sum_q;
  logic [WGT_W-1:0]  weight_sum_q;
  logic [WGT_W-1:0]  frame_total_q;
  logic [POS_W-1:0]  held_pos_q;

  // Per-item working registers.
  logic [IDX_IN_W-1:0] idx_q;
  logic [TIME_W-1:0]   raw_q;
  logic [TIME_W-1:0]   span_q, delta_q;
  logic [WGT_W-1:0]    weight_q;
  logic [NORM_W-1:0]   norm_q;
  logic [PROD_W-1:0]   product_q;

  // Shared divider.
  logic [WSUM_W-1:0] div_num_q, div_quo_q;
  logic [WGT_W-1:0]  div_den_q;
  logic [WGT_W:0]    div_rem_q;
  logic [CNT_W-1:0]  div_cnt_q;
  logic [WGT_W:0]    rem_shift, rem_next;
  logic              rem_ge;

  // Result register.
  logic             m_valid_q;
  logic [POS_W-1:0] m_pos_q;
  logic             m_fresh_q, m_detect_q;

  logic              in_accept, in_range, out_free, fresh, detected;
  logic              in_div, frame_done;
  kind_e             in_kind;
  logic [IDX_IN_W-1:0] in_idx;
  logic [TIME_W-1:0] in_raw, raw_sat;
  logic [IDX_W-1:0]  in_sel, cur_sel;
  logic [TIME_W-1:0] cur_lo, cur_hi, span_w, delta_w;
  logic [POS_W-1:0]  pos_w;
  logic [THR_W-1:0]  threshold;
  logic [WGT_W:0]    ft_sum, ws_sum;
  logic [WSUM_W:0]   wsum_sum;

  assign in_kind   = kind_e'(s_axis_tuser_i[KIND_W-1:0]);
  assign in_idx    = s_axis_tdata_i[IDX_IN_W-1:0];
  assign in_raw    = s_axis_tdata_i[IDX_IN_W +: TIME_W];
  assign raw_sat   = (in_raw > TIMEOUT_V) ? TIMEOUT_V : in_raw;
  assign in_range  = {1'b0, in_idx} < (IDX_IN_W+1)'(SENSOR_COUNT);
  assign in_sel    = in_idx[IDX_W-1:0];
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign cur_sel   = idx_q[IDX_W-1:0];
  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign cfg_ready_o = 1'b1;
  assign in_div     = (state_q == ST_DIV_NORM) || (state_q == ST_DIV_POS);
  assign frame_done = (state_q == ST_FINISH) && out_free;

  // Span and clamped offset of the current sample.
  assign cur_lo  = cal_low_q[cur_sel];
  assign cur_hi  = cal_high_q[cur_sel];
  assign span_w  = (cur_hi > cur_lo) ? (cur_hi - cur_lo) : TIME_W'(1);
  always_comb begin
    delta_w = (raw_q > cur_lo) ? (raw_q - cur_lo) : '0;
    if (delta_w > span_w) begin
      delta_w = span_w;
    end
  end

  // One restoring division step.
  assign rem_shift = {div_rem_q[WGT_W-1:0], div_num_q[WSUM_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, div_den_q};
  assign rem_next  = rem_ge ? (rem_shift - {1'b0, div_den_q}) : rem_shift;

  // Saturating accumulator sums.
  assign ft_sum   = {1'b0, frame_total_q} + (WGT_W+1)'(norm_q);
  assign ws_sum   = {1'b0, weight_sum_q} + (WGT_W+1)'(norm_q);
  assign wsum_sum = {1'b0, weighted_sum_q} + (WSUM_W+1)'(product_q);

  // End-of-frame figures.
  assign fresh     = weight_sum_q != '0;
  assign pos_w     = (div_quo_q > WSUM_W'(POS_LIMIT)) ? POS_W'(POS_LIMIT)
                                                      : div_quo_q[POS_W-1:0];
  assign threshold = THR_W'(confidence_q) * THR_W'(SENSOR_COUNT);
  assign detected  = (THR_W'(frame_total_q)) >= threshold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i && in_kind == KIND_MEASURE && in_range) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE:    state_d = ST_MUL;
      ST_MUL:      state_d = ST_DIV_NORM;
      ST_DIV_NORM: if (div_cnt_q == CNT_W'(1)) state_d = ST_PROD;
      ST_PROD:     state_d = ST_ACCUM;
      ST_ACCUM:    state_d = (idx_q == LAST_IDX) ? ST_CHECK : ST_IDLE;
      ST_CHECK:    state_d = fresh ? ST_DIV_POS : ST_FINISH;
      ST_DIV_POS:  if (div_cnt_q == CNT_W'(1)) state_d = ST_FINISH;
      ST_FINISH:   if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Registers, tables, accumulators and result flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_min_q   <= TIME_W'(PRESET_MIN_RST);
      preset_max_q   <= TIME_W'(PRESET_MAX_RST);
      noise_floor_q  <= NORM_W'(NOISE_RST);
      confidence_q   <= NORM_W'(CONF_RST);
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        cal_low_q[i]  <= TIMEOUT_V;
        cal_high_q[i] <= '0;
      end
      weighted_sum_q <= '0;
      weight_sum_q   <= '0;
      frame_total_q  <= '0;
      held_pos_q     <= POS_W'(HELD_RESET);
      m_valid_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_PRESET_MIN:  preset_min_q  <= cfg_data_i;
          REG_PRESET_MAX:  preset_max_q  <= cfg_data_i;
          REG_NOISE_FLOOR: noise_floor_q <= cfg_data_i[NORM_W-1:0];
          REG_CONFIDENCE:  confidence_q  <= cfg_data_i[NORM_W-1:0];
        endcase
      end

      if (in_accept) begin
        unique case (in_kind)
          KIND_CLEAR: begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
              cal_low_q[i]  <= TIMEOUT_V;
              cal_high_q[i] <= '0;
            end
          end
          KIND_PRESET: begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
              cal_low_q[i]  <= preset_min_q;
              cal_high_q[i] <= preset_max_q;
            end
          end
          KIND_CALIBRATE: begin
            if (in_range) begin
              if (raw_sat < cal_low_q[in_sel]) cal_low_q[in_sel] <= raw_sat;
              if (raw_sat > cal_high_q[in_sel]) cal_high_q[in_sel] <= raw_sat;
            end
          end
          KIND_MEASURE: ;
        endcase
      end

      if (state_q == ST_ACCUM) begin
        frame_total_q <= ft_sum[WGT_W] ? WGT_MAX : ft_sum[WGT_W-1:0];
        if (norm_q > noise_floor_q) begin
          weight_sum_q   <= ws_sum[WGT_W] ? WGT_MAX : ws_sum[WGT_W-1:0];
          weighted_sum_q <= wsum_sum[WSUM_W] ? WSUM_MAX : wsum_sum[WSUM_W-1:0];
        end
      end

      if (frame_done) begin
        m_valid_q      <= 1'b1;
        if (fresh) held_pos_q <= pos_w;
        weighted_sum_q <= '0;
        weight_sum_q   <= '0;
        frame_total_q  <= '0;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Working registers, the shared divider and the result fields.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      idx_q <= in_idx;
      raw_q <= raw_sat;
    end
    unique case (state_q)
      ST_SCALE: begin
        span_q   <= span_w;
        delta_q  <= delta_w;
        weight_q <= WGT_W'(idx_q) * WGT_W'(FULL_SCALE);
      end
      ST_MUL: begin
        div_num_q <= {DPROD_W'(delta_q) * DPROD_W'(FULL_SCALE), {(WSUM_W-DPROD_W){1'b0}}};
        div_den_q <= WGT_W'(span_q);
        div_rem_q <= '0;
        div_quo_q <= '0;
        div_cnt_q <= NORM_STEPS;
      end
      ST_CHECK: begin
        div_num_q <= weighted_sum_q;
        div_den_q <= weight_sum_q;
        div_rem_q <= '0;
        div_quo_q <= '0;
        div_cnt_q <= POS_STEPS;
      end
      ST_DIV_NORM, ST_DIV_POS: begin
        div_num_q <= {div_num_q[WSUM_W-2:0], 1'b0};
        div_rem_q <= rem_next;
        div_quo_q <= {div_quo_q[WSUM_W-2:0], rem_ge};
        div_cnt_q <= div_cnt_q - CNT_W'(1);
      end
      ST_PROD: begin
        // The quotient of the scaling division never exceeds full scale.
        norm_q    <= div_quo_q[NORM_W-1:0];
        product_q <= PROD_W'(div_quo_q[NORM_W-1:0]) * PROD_W'(weight_q);
      end
      ST_FINISH: begin
        if (out_free) begin
          m_pos_q    <= fresh ? pos_w : held_pos_q;
          m_fresh_q  <= fresh;
          m_detect_q <= detected;
        end
      end
      ST_IDLE, ST_ACCUM: ;
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = M_DATA_W'(m_pos_q);
  assign m_axis_tuser_o  = {m_detect_q, m_fresh_q};

  `ASSERT_IMPLIES(a_held_in_range, 1'b1, held_pos_q <= POS_W'(POS_MAX), "held position range")
  `ASSERT_IMPLIES(a_div_count_live, in_div, div_cnt_q != '0, "divider ran past its last step")
  `ASSERT_NEXT(a_frame_cleared, frame_done, (frame_total_q == '0) && m_valid_q, "sums not cleared")

endmodule

// ===== sim/line_sensor_position_estimator_test.sv =====
// Self-checking testbench for line_sensor_position_estimator: a directed table, then
// random frames under several register settings, with random stalls on both streams.
// Depends on lspe_pkg and the block's RTL; expected results come from a local model or typed rows.

module line_sensor_position_estimator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lspe_pkg::*;

  localparam int SENSORS       = DEFAULT_SENSOR_COUNT;
  localparam int TIME_CAP      = DEFAULT_TIMEOUT;
  localparam int WSUM_LIMIT    = (1 << WSUM_W) - 1;
  localparam int WGT_LIMIT     = (1 << WGT_W) - 1;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 135;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             fresh;
    logic             detected;
  } line_result_t;

  // One directed item; the result fields are used only where typed is set.
  typedef struct packed {
    kind_e             kind;
    logic [3:0]        idx;
    logic [TIME_W-1:0] raw;
    logic              typed;
    logic [POS_W-1:0]  position;
    logic              fresh;
    logic              detected;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                item_valid = 1'b0;
  logic [S_DATA_W-1:0] item_data = '0;
  kind_e               item_kind = KIND_MEASURE;
  logic                result_ready = 1'b0;
  logic                reg_valid = 1'b0;
  cfg_reg_e            reg_index = REG_PRESET_MIN;
  logic [CFG_W-1:0]    reg_data = '0;

  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [M_DATA_W-1:0] m_axis_tdata_o;
  logic [M_USER_W-1:0] m_axis_tuser_o;
  logic                cfg_ready_o;

  // Model state: per-sensor calibration bounds, frame sums and the held position.
  logic [TIME_W-1:0] sens_min [SENSORS];
  logic [TIME_W-1:0] sens_max [SENSORS];
  int                pos_weighted;
  int                norm_sum;
  int                level_sum;
  int                held_pos;
  logic [TIME_W-1:0] preset_lo;
  logic [TIME_W-1:0] preset_hi;
  logic [NORM_W-1:0] noise_level;
  logic [NORM_W-1:0] confidence;

  line_result_t expected_positions [$];
  int           mismatches = 0;
  int           items_sent = 0;
  int           cycle_count = 0;
  bit           quiet = 1'b0;

  stim_row_t directed_rows [23] = '{
    '{KIND_MEASURE,   4'd8,  12'd0,    1'b1, 13'd4000, 1'b0, 1'b0},
    '{KIND_MEASURE,   4'd15, 12'd4095, 1'b0, 13'd0,    1'b0, 1'b0},
    '{KIND_CALIBRATE, 4'd12, 12'd100,  1'b0, 13'd0,    1'b0, 1'b0},
    '{KIND_PRESET,    4'd5,  12'd77,   1'b0, 13'd0,    1'b0, 1'b0},
    '{KIND_MEASURE,   4'd8,  12'd4095, 1'b1, 13'd8000, 1'b1, 1'b0},
    '{KIND_MEASURE,   4'd0,  12'd4095, 1'b0, 13'd0,    1'b0, 1'b0},
    '{KIND_MEASURE,   4'd8,  12'd45,   1'b1, 13'd0,    1'b1, 1'b0},
    '{KIND_MEASURE,   4'd0,  12'd600,  1'b0, 13'd0,    1'b0, 1'b0},
    '{KIND_MEASURE,   4'd1,  12'd600,  1'b0, 13'd0,    1'b0, 1'b0},
    '{KIND_MEASURE,   4'd2,  12'd600,  1'b0, 13'd0,    1'b0, 1'b0},
    '{KIND_MEASURE,   4'd3,  12'd600,  1'b0, 13'd0,    1'b0, 1'b0},
    '{KIND_MEASURE,   4'd4,  12'd600,  1'b0, 13'd0,    1'b0, 1'b0},
    '{KIND_MEASURE,   4'd5,  12'd600,  1'b0, 13'd0,    1'b0, 1'b0},
    '{KIND_MEASURE,   4'd6,  12'd600,  1'b0, 13'd0,    1'b0, 1'b0},
    '{KIND_MEASURE,   4'd7,  12'd600,  1'b0, 13'd0,    1'b0, 1'b0},
    '{KIND_MEASURE,   4'd8,  12'd600,  1'b1, 13'd4000, 1'b1, 1'b1},
    '{KIND_MEASURE,   4'd2,  12'd101,  1'b0, 13'd0,    1'b0, 1'b0},
    '{KIND_MEASURE,   4'd8,  12'd44,   1'b0, 13'd0,    1'b0, 1'b0},
    '{KIND_CLEAR,     4'd3,  12'd999,  1'b0, 13'd0,    1'b0, 1'b0},
    '{KIND_CALIBRATE, 4'd4,  12'd300,  1'b0, 13'd0,    1'b0, 1'b0},
    '{KIND_MEASURE,   4'd4,  12'd301,  1'b0, 13'd0,    1'b0, 1'b0},
    '{KIND_CALIBRATE, 4'd8,  12'd4095, 1'b0, 13'd0,    1'b0, 1'b0},
    '{KIND_MEASURE,   4'd8,  12'd4095, 1'b0, 13'd0,    1'b0, 1'b0}
  };

  line_sensor_position_estimator #(
    .SENSOR_COUNT(SENSORS),
    .TIMEOUT     (TIME_CAP)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(item_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (item_data),
    .s_axis_tuser_i (item_kind),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(result_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (reg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (reg_index),
    .cfg_data_i     (reg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("line_sensor_position_estimator: mismatch");
      $finish;
    end
  end

  function automatic int pick_gap();
    return quiet ? 0 : int'($urandom_range(0, 14));
  endfunction

  // Mostly values near the calibrated band, sometimes anywhere, sometimes past the timeout.
  function automatic logic [TIME_W-1:0] pick_raw();
    case ($urandom_range(0, 9))
      0: return TIME_W'($urandom_range(0, 4095));
      1: return TIME_W'($urandom_range(2400, 4095));
      default: return TIME_W'($urandom_range(0, 1000));
    endcase
  endfunction

  function automatic void apply_register(input cfg_reg_e which, input logic [CFG_W-1:0] value);
    case (which)
      REG_PRESET_MIN:  preset_lo = value;
      REG_PRESET_MAX:  preset_hi = value;
      REG_NOISE_FLOOR: noise_level = value[NORM_W-1:0];
      REG_CONFIDENCE:  confidence = value[NORM_W-1:0];
      default: ;
    endcase
  endfunction

  // Updates the model for one accepted item; returns 1 when the item closes a frame.
  function automatic bit advance_estimator(input kind_e kind, input logic [3:0] idx,
                                           input logic [TIME_W-1:0] raw_in,
                                           output line_result_t res);
    int raw, lo, span, delta, norm, pos;
    raw = raw_in;
    res = '0;
    if (raw > TIME_CAP) raw = TIME_CAP;
    if (kind == KIND_CLEAR) begin
      for (int s = 0; s < SENSORS; s++) begin
        sens_min[s] = TIME_W'(TIME_CAP);
        sens_max[s] = '0;
      end
      return 1'b0;
    end
    if (kind == KIND_PRESET) begin
      for (int s = 0; s < SENSORS; s++) begin
        sens_min[s] = preset_lo;
        sens_max[s] = preset_hi;
      end
      return 1'b0;
    end
    if (idx >= SENSORS) return 1'b0;
    if (kind == KIND_CALIBRATE) begin
      if (raw < sens_min[idx]) sens_min[idx] = TIME_W'(raw);
      if (raw > sens_max[idx]) sens_max[idx] = TIME_W'(raw);
      return 1'b0;
    end

    lo = sens_min[idx];
    span = int'(sens_max[idx]) - lo;
    delta = raw - lo;
    if (span <= 0) span = 1;
    if (delta < 0) delta = 0;
    if (delta > span) delta = span;
    norm = delta * FULL_SCALE / span;

    level_sum = (level_sum + norm > WGT_LIMIT) ? WGT_LIMIT : level_sum + norm;
    if (norm > noise_level) begin
      pos_weighted = (pos_weighted + norm * int'(idx) * FULL_SCALE > WSUM_LIMIT) ?
                     WSUM_LIMIT : pos_weighted + norm * int'(idx) * FULL_SCALE;
      norm_sum = (norm_sum + norm > WGT_LIMIT) ? WGT_LIMIT : norm_sum + norm;
    end
    if (idx != SENSORS - 1) return 1'b0;

    res.fresh = (norm_sum != 0);
    if (res.fresh) begin
      pos = pos_weighted / norm_sum;
      if (pos > (SENSORS - 1) * FULL_SCALE) pos = (SENSORS - 1) * FULL_SCALE;
      if (pos > POS_MAX) pos = POS_MAX;
      held_pos = pos;
    end
    res.position = POS_W'(held_pos);
    res.detected = (level_sum >= int'(confidence) * SENSORS);
    pos_weighted = 0;
    norm_sum = 0;
    level_sum = 0;
    return 1'b1;
  endfunction

  // Entered and left at a rising edge; valid stays high when the next item follows at once.
  task automatic send_item(input kind_e kind, input logic [3:0] idx,
                           input logic [TIME_W-1:0] raw, input bit typed,
                           input line_result_t typed_res);
    int gap;
    line_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_valid <= 1'b1;
    item_kind <= kind;
    item_data <= {raw, idx};
    @(negedge clk_i);
    while (!s_axis_tready_o) @(negedge clk_i);
    @(posedge clk_i);
    if (advance_estimator(kind, idx, raw, res))
      expected_positions.push_back(typed ? typed_res : res);
    if (idx < SENSORS || kind == KIND_CLEAR || kind == KIND_PRESET) items_sent++;
  endtask

  // Waits for every outstanding result, then for the block to finish any silent item.
  task automatic drain_results();
    item_valid <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_settings(input logic [CFG_W-1:0] lo_val, input logic [CFG_W-1:0] hi_val,
                                input logic [CFG_W-1:0] noise_val,
                                input logic [CFG_W-1:0] conf_val);
    cfg_reg_e         regs [4] = '{REG_PRESET_MIN, REG_PRESET_MAX, REG_NOISE_FLOOR,
                                   REG_CONFIDENCE};
    logic [CFG_W-1:0] vals [4];
    vals = '{lo_val, hi_val, noise_val, conf_val};
    for (int i = 0; i < 4; i++) begin
      reg_valid <= 1'b1;
      reg_index <= regs[i];
      reg_data <= vals[i];
      @(negedge clk_i);
      while (!cfg_ready_o) @(negedge clk_i);
      @(posedge clk_i);
      apply_register(regs[i], vals[i]);
    end
    reg_valid <= 1'b0;
  endtask

  task automatic run_random(input int target);
    int first, choice, count;
    first = items_sent;
    while (items_sent - first < target) begin
      quiet = ($urandom_range(0, 3) == 0);
      choice = $urandom_range(0, 99);
      if (choice < 5) begin
        send_item(kind_e'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                  TIME_W'($urandom_range(0, 4095)), 1'b0, '0);
      end else if (choice < 10) begin
        send_item(KIND_PRESET, 4'($urandom_range(0, 15)), pick_raw(), 1'b0, '0);
      end else if (choice < 14) begin
        // Fresh calibration; skipped sensors keep an empty span.
        send_item(KIND_CLEAR, 4'($urandom_range(0, 15)), pick_raw(), 1'b0, '0);
        for (int s = 0; s < SENSORS; s++) begin
          if ($urandom_range(0, 7) != 0) begin
            count = $urandom_range(1, 3);
            repeat (count) send_item(KIND_CALIBRATE, 4'(s), pick_raw(), 1'b0, '0);
          end
        end
      end else if (choice < 17) begin
        // Long frame of strong samples to drive the sums into saturation.
        repeat (20) send_item(KIND_MEASURE, 4'(SENSORS - 2), 12'd4095, 1'b0, '0);
        send_item(KIND_MEASURE, 4'(SENSORS - 1), 12'd4095, 1'b0, '0);
      end else if (choice < 22) begin
        count = $urandom_range(1, 12);
        repeat (count)
          send_item(KIND_MEASURE, 4'($urandom_range(0, 10)), pick_raw(), 1'b0, '0);
      end else if (choice < 25) begin
        drain_results();
      end else begin
        for (int s = 0; s < SENSORS; s++) send_item(KIND_MEASURE, 4'(s), pick_raw(), 1'b0, '0);
      end
    end
  endtask

  // Result side: a random stall before each result, then ready until it is taken.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_ready <= 1'b1;
      @(negedge clk_i);
      while (!m_axis_tvalid_o) @(negedge clk_i);
      @(posedge clk_i);
    end
  end

  // Inputs change only at rising edges, so a handshake seen here completes at the next one.
  always @(negedge clk_i) begin
    line_result_t want;
    if (rst_ni && m_axis_tvalid_o && result_ready) begin
      if (expected_positions.size() == 0) begin
        $error("unexpected result item: line_position %0d", m_axis_tdata_o[POS_W-1:0]);
        mismatches++;
      end else begin
        want = expected_positions.pop_front();
        if (m_axis_tdata_o[POS_W-1:0] !== want.position) begin
          $error("line_position: expected %0d, actual %0d", want.position,
                 m_axis_tdata_o[POS_W-1:0]);
          mismatches++;
        end
        if (m_axis_tuser_o[0] !== want.fresh) begin
          $error("position_fresh: expected %0d, actual %0d", want.fresh, m_axis_tuser_o[0]);
          mismatches++;
        end
        if (m_axis_tuser_o[1] !== want.detected) begin
          $error("line_detected: expected %0d, actual %0d", want.detected, m_axis_tuser_o[1]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stim_row_t        row;
    logic [CFG_W-1:0] lo_val, hi_val, noise_val, conf_val;
    for (int s = 0; s < SENSORS; s++) begin
      sens_min[s] = TIME_W'(TIME_CAP);
      sens_max[s] = '0;
    end
    pos_weighted = 0;
    norm_sum = 0;
    level_sum = 0;
    held_pos = HELD_RESET;
    preset_lo = TIME_W'(PRESET_MIN_RST);
    preset_hi = TIME_W'(PRESET_MAX_RST);
    noise_level = NORM_W'(NOISE_RST);
    confidence = NORM_W'(CONF_RST);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_item(row.kind, row.idx, row.raw, row.typed, {row.position, row.fresh, row.detected});
    end
    drain_results();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: {lo_val, hi_val, noise_val, conf_val} = {12'd0, 12'd4095, 12'd0, 12'd0};
        1: {lo_val, hi_val, noise_val, conf_val} = {12'd4095, 12'd0, 12'd1000, 12'd1000};
        2: {lo_val, hi_val, noise_val, conf_val} = {12'd45, 12'd600, 12'd100, 12'd500};
        default: begin
          lo_val = CFG_W'($urandom_range(0, 1500));
          hi_val = CFG_W'($urandom_range(0, 2600));
          noise_val = CFG_W'($urandom_range(0, 1000));
          conf_val = CFG_W'($urandom_range(0, 1000));
        end
      endcase
      write_settings(lo_val, hi_val, noise_val, conf_val);
      run_random(PHASE_ITEMS);
      drain_results();
    end

    if (mismatches == 0) begin
      $display("line_sensor_position_estimator: match");
    end else begin
      $display("line_sensor_position_estimator: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/lspe_pkg.sv
sv/line_sensor_position_estimator.sv
sim/line_sensor_position_estimator_test.sv
